### hdl/cc12_pkg.sv
package cc12_pkg;

    // Default number of rounds; odd values run one extra round.
    localparam int ROUNDS_DEFAULT = 12;

    localparam int WORDS = 16;
    localparam int KEY_WORDS = 12;

    // Fill words for the leading state positions not taken by key words.
    localparam logic [31:0] FILL_WORDS [KEY_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13
    };

    // Configuration register indexes.
    localparam logic [2:0] CFG_KEY_0_1   = 3'd0;
    localparam logic [2:0] CFG_KEY_2_3   = 3'd1;
    localparam logic [2:0] CFG_KEY_4_5   = 3'd2;
    localparam logic [2:0] CFG_KEY_6_7   = 3'd3;
    localparam logic [2:0] CFG_KEY_8_9   = 3'd4;
    localparam logic [2:0] CFG_KEY_10_11 = 3'd5;
    localparam logic [2:0] CFG_NONCE     = 3'd6;
    localparam logic [2:0] CFG_KEY_COUNT = 3'd7;

    localparam logic [3:0] KEY_COUNT_RESET = 4'd12;

    typedef logic [WORDS-1:0][31:0] t_words;

    typedef struct packed {
        logic [63:0] data_in;
        logic [3:0]  byte_count;
        logic        start_message;
        logic        end_call;
    } t_in_item;

    typedef struct packed {
        logic [63:0] data_out;
        logic [3:0]  valid_bytes;
        logic        last_of_call;
    } t_out_item;

endpackage

### hdl/chacha12_stream_xor.sv
// Channel   Direction  Handshake                Payload
// in        sink       i_in_valid / o_in_stall  i_in_data  (cc12_pkg::t_in_item)
// out       source     o_out_valid / i_out_stall o_out_data (cc12_pkg::t_out_item)
// cfg       sink       i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// A word that finds keystream left is accepted, then XORed into the output
// register. A word that needs a new block first goes through load, the rounds and
// the final add: one add-xor-rotate step per cycle, 32 per double round.
// Reset is synchronous, active low: zero the counter and position, restore config defaults.
// The input stalls while a transaction is in work; a stalled output holds its
// transaction while the next input is already taken.
module chacha12_stream_xor #(
    parameter int ROUNDS = cc12_pkg::ROUNDS_DEFAULT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  cc12_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output cc12_pkg::t_out_item  o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [2:0]           i_cfg_index,
    input  logic [63:0]          i_cfg_data
);

    localparam int DOUBLE_ROUNDS = (ROUNDS + 1) / 2;
    localparam int DR_W = (DOUBLE_ROUNDS > 1) ? $clog2(DOUBLE_ROUNDS) : 1;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_LOAD  = 5'b00010,
        ST_ROUND = 5'b00100,
        ST_FINAL = 5'b01000,
        ST_XOR   = 5'b10000
    } t_state;

    // Per-row left rotation amounts applied after the last step of a
    // quarter-round, so the next column or diagonal lands in column 0.
    localparam logic [3:0][1:0] ROT_NEXT     = {2'd1, 2'd1, 2'd1, 2'd1};
    localparam logic [3:0][1:0] ROT_TO_DIAG  = {2'd0, 2'd3, 2'd2, 2'd1};
    localparam logic [3:0][1:0] ROT_TO_COLS  = {2'd2, 2'd3, 2'd0, 2'd1};

    function automatic cc12_pkg::t_words rot_rows(input cc12_pkg::t_words v,
                                                  input logic [3:0][1:0] amt);
        cc12_pkg::t_words res;
        logic [1:0]       src;
        for (int r = 0; r < 4; r++) begin
            for (int j = 0; j < 4; j++) begin
                src = 2'(j) + amt[r];
                res[4*r + j] = v[4*r + int'(src)];
            end
        end
        return res;
    endfunction

    // Control state
    t_state            r_state, n_state;
    logic [63:0]       r_ctr, n_ctr;
    logic [2:0]        r_pos, n_pos;
    logic              r_ks_ready, n_ks_ready;
    logic [1:0]        r_step, n_step;
    logic [2:0]        r_qr, n_qr;
    logic [DR_W-1:0]   r_dr, n_dr;
    logic              r_out_valid, n_out_valid;

    // Configuration
    logic [5:0][63:0]  r_key;
    logic [63:0]       r_nonce;
    logic [3:0]        r_key_count;

    // Payload
    cc12_pkg::t_words    r_w, n_w;
    cc12_pkg::t_in_item  r_item, n_item;
    cc12_pkg::t_out_item r_out, n_out;

    // Input state words, built from configuration and counter
    cc12_pkg::t_words  st;
    logic [3:0]        key_n;
    logic [3:0]        lead;
    logic [383:0]      key_shifted;

    always_comb begin
        key_n = (r_key_count > 4'd12) ? 4'd12 : r_key_count;
        lead  = 4'd12 - key_n;
        // Right-align the used key words: key word i lands in slot lead + i.
        key_shifted = r_key << {lead, 5'b0};
        for (int i = 0; i < cc12_pkg::KEY_WORDS; i++) begin
            if (4'(i) < lead) begin
                st[i] = cc12_pkg::FILL_WORDS[i];
            end else begin
                st[i] = key_shifted[32*i +: 32];
            end
        end
        st[12] = r_ctr[31:0];
        st[13] = r_ctr[63:32];
        st[14] = r_nonce[31:0];
        st[15] = r_nonce[63:32];
    end

    // Shared add-xor-rotate unit. Even steps work on a (word 0), b, d;
    // odd steps on c, d, b, all in column 0.
    logic [31:0]       op_x, op_y, op_z, op_sum, op_mix, op_rot;
    cc12_pkg::t_words  step_w, step_upd;

    always_comb begin
        op_x   = r_step[0] ? r_w[8]  : r_w[0];
        op_y   = r_step[0] ? r_w[12] : r_w[4];
        op_z   = r_step[0] ? r_w[4]  : r_w[12];
        op_sum = op_x + op_y;
        op_mix = op_z ^ op_sum;
        case (r_step)
            2'd0:    op_rot = {op_mix[15:0], op_mix[31:16]};
            2'd1:    op_rot = {op_mix[19:0], op_mix[31:20]};
            2'd2:    op_rot = {op_mix[23:0], op_mix[31:24]};
            default: op_rot = {op_mix[24:0], op_mix[31:25]};
        endcase
        step_upd = r_w;
        if (r_step[0]) begin
            step_upd[8] = op_sum;
            step_upd[4] = op_rot;
        end else begin
            step_upd[0]  = op_sum;
            step_upd[12] = op_rot;
        end
        if (r_step == 2'd3) begin
            if (r_qr == 3'd3) begin
                step_w = rot_rows(step_upd, ROT_TO_DIAG);
            end else if (r_qr == 3'd7) begin
                step_w = rot_rows(step_upd, ROT_TO_COLS);
            end else begin
                step_w = rot_rows(step_upd, ROT_NEXT);
            end
        end else begin
            step_w = step_upd;
        end
    end

    // XOR stage: pick the 64-bit keystream row at the current position
    logic [7:0][63:0]  w_rows;
    logic [63:0]       ks;
    logic [3:0]        nb;
    cc12_pkg::t_out_item xor_item;

    always_comb begin
        w_rows = r_w;
        ks     = w_rows[r_pos];
        nb     = (r_item.byte_count > 4'd8) ? 4'd8 : r_item.byte_count;
        for (int b = 0; b < 8; b++) begin
            if (4'(b) < nb) begin
                xor_item.data_out[8*b +: 8] = r_item.data_in[8*b +: 8] ^ ks[8*b +: 8];
            end else begin
                xor_item.data_out[8*b +: 8] = 8'h00;
            end
        end
        xor_item.valid_bytes  = r_item.byte_count;
        xor_item.last_of_call = r_item.end_call;
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_ctr       = r_ctr;
        n_pos       = r_pos;
        n_ks_ready  = r_ks_ready;
        n_step      = r_step;
        n_qr        = r_qr;
        n_dr        = r_dr;
        n_out_valid = r_out_valid;
        n_w         = r_w;
        n_item      = r_item;
        n_out       = r_out;

        // Drop the output transaction once taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_item = i_in_data;
                    if (i_in_data.start_message) begin
                        n_pos      = 3'd0;
                        n_ks_ready = 1'b0;
                    end
                    if (!i_in_data.start_message && r_ks_ready) begin
                        n_state = ST_XOR;
                    end else begin
                        // Advance the counter before the block is built
                        n_ctr   = (i_in_data.start_message ? 64'd0 : r_ctr) + 64'd1;
                        n_state = ST_LOAD;
                    end
                end
            end
            ST_LOAD: begin
                n_w     = st;
                n_step  = 2'd0;
                n_qr    = 3'd0;
                n_dr    = '0;
                n_state = ST_ROUND;
            end
            ST_ROUND: begin
                n_w    = step_w;
                n_step = r_step + 2'd1;
                if (r_step == 2'd3) begin
                    n_qr = r_qr + 3'd1;
                    if (r_qr == 3'd7) begin
                        if (r_dr == DR_W'(DOUBLE_ROUNDS - 1)) begin
                            n_state = ST_FINAL;
                        end else begin
                            n_dr = r_dr + DR_W'(1);
                        end
                    end
                end
            end
            ST_FINAL: begin
                for (int i = 0; i < cc12_pkg::WORDS; i++) begin
                    n_w[i] = r_w[i] + st[i];
                end
                n_ks_ready = 1'b1;
                n_pos      = 3'd0;
                n_state    = ST_XOR;
            end
            ST_XOR: begin
                // Hold until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = xor_item;
                    n_out_valid = 1'b1;
                    if (r_pos == 3'd7 || r_item.end_call) begin
                        n_pos      = 3'd0;
                        n_ks_ready = 1'b0;
                    end else begin
                        n_pos = r_pos + 3'd1;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ctr       <= 64'd0;
            r_pos       <= 3'd0;
            r_ks_ready  <= 1'b0;
            r_step      <= 2'd0;
            r_qr        <= 3'd0;
            r_dr        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ctr       <= n_ctr;
            r_pos       <= n_pos;
            r_ks_ready  <= n_ks_ready;
            r_step      <= n_step;
            r_qr        <= n_qr;
            r_dr        <= n_dr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w    <= n_w;
        r_item <= n_item;
        r_out  <= n_out;
    end

    // Configuration writes; always accepted
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key       <= '0;
            r_nonce     <= 64'd0;
            r_key_count <= cc12_pkg::KEY_COUNT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index) inside
                cc12_pkg::CFG_KEY_0_1, cc12_pkg::CFG_KEY_2_3, cc12_pkg::CFG_KEY_4_5,
                cc12_pkg::CFG_KEY_6_7, cc12_pkg::CFG_KEY_8_9,
                cc12_pkg::CFG_KEY_10_11: begin
                    r_key[i_cfg_index] <= i_cfg_data;
                end
                cc12_pkg::CFG_NONCE: begin
                    r_nonce <= i_cfg_data;
                end
                cc12_pkg::CFG_KEY_COUNT: begin
                    r_key_count <= i_cfg_data[3:0];
                end
                default: begin
                    r_nonce <= r_nonce;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

endmodule
